// ===== hdl/swms_pkg.sv =====
`default_nettype none

package swms_pkg;

    // Window geometry
    localparam int WINDOW_MAX = 16;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);

    // Field widths
    localparam int SAMPLE_W = 63;
    localparam int CNT_W    = 5;
    localparam int SUM_W    = 68;

    // Serial divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Register port
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;
    localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;
    localparam logic [CNT_W-1:0]   WINDOW_SIZE_RESET = CNT_W'(16);

    // Window size as used: zero acts as one, above the bound saturates
    function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] ws);
        logic [CNT_W-1:0] s;
        s = ws;
        if (s == '0) begin
            s = CNT_W'(1);
        end
        if (s > CNT_W'(WINDOW_MAX)) begin
            s = CNT_W'(WINDOW_MAX);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/swms_ring.sv =====
`default_nettype none

module swms_ring
    import swms_pkg::*;
(
    input  wire                 aclk,
    input  wire                 wr_en,
    input  wire  [SLOT_W-1:0]   wr_addr,
    input  wire  [SAMPLE_W-1:0] wr_data,
    input  wire                 rd_en,
    input  wire  [SLOT_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, data follows rd_en in the next cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swms_div.sv =====
`default_nettype none

module swms_div
    import swms_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire  [SUM_W-1:0]    dividend,
    input  wire  [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [SAMPLE_W-1:0] quotient
);

    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // Restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= STEP_W'(DIV_STEPS);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out on top, quotient bits enter below
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (step_reg != '0) begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/sliding_window_mean_and_spread_core.sv =====
`default_nettype none

// Sliding window mean and spread of 63-bit latency samples. Each accepted
// sample enters a 16-entry ring; the block then reports the truncated mean,
// the spread (largest minus smallest) and the count of the newest samples held,
// up to window_size (APB register at address 0, reset 16; zero acts as one).
// Shrinking the window drops the oldest samples at once. After a sample is
// accepted, the ring is scanned one entry per cycle over its single read port,
// the 68-bit sum is divided by a bit-serial divider in 68 steps, and the result
// is registered for m_; a new sample is taken only after that result is loaded.
// The next sample is accepted while a result still waits on m_.

module sliding_window_mean_and_spread_core
    import swms_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [SAMPLE_W-1:0] s_sample,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [SAMPLE_W-1:0] m_mean_value,
    output logic [SAMPLE_W-1:0] m_spread,
    output logic [CNT_W-1:0]    m_held_count,

    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [PADDR_W-1:0]  paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [SLOT_W:0] WMAX_S = (SLOT_W+1)'(WINDOW_MAX);

    state_t              state_reg;
    logic [CNT_W-1:0]    ws_reg;
    logic [SLOT_W-1:0]   wslot_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                rd_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] spread_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                in_fire;
    logic                cfg_wr;
    logic [CNT_W-1:0]    eff;
    logic [CNT_W-1:0]    eff_wr;
    logic [CNT_W-1:0]    fill_next;
    logic                issue;
    logic                scan_end;
    logic [SLOT_W:0]     age_sum;
    logic [SLOT_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_done;
    logic [SAMPLE_W-1:0] quotient;
    logic                out_load;

    // Handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite
                      && (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);
    assign prdata   = (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE)
                      ? {{(DATA_W-CNT_W){1'b0}}, ws_reg} : '0;

    // Fill count after a sample arrives
    assign eff       = eff_size(ws_reg);
    assign eff_wr    = eff_size(pwdata[CNT_W-1:0]);
    assign fill_next = (fill_reg < eff) ? fill_reg + 1'b1 : eff;

    // Scan the newest samples, age k at slot write_slot - 1 - k
    assign issue    = (state_reg == ST_SCAN) && (k_reg != fill_reg);
    assign scan_end = (state_reg == ST_SCAN) && !issue && !rd_valid_reg;
    assign age_sum  = {1'b0, wslot_reg} + (WMAX_S - 1'b1) - (SLOT_W+1)'(k_reg);
    assign rd_addr  = (age_sum >= WMAX_S) ? SLOT_W'(age_sum - WMAX_S)
                                          : SLOT_W'(age_sum);

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    swms_ring u_ring (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (wslot_reg),
        .wr_data (s_sample),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_end),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer, window state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ws_reg       <= WINDOW_SIZE_RESET;
            wslot_reg    <= '0;
            fill_reg     <= '0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (cfg_wr) begin
                ws_reg <= pwdata[CNT_W-1:0];
                if (fill_reg > eff_wr) begin
                    fill_reg <= eff_wr;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        wslot_reg <= (wslot_reg == SLOT_W'(WINDOW_MAX - 1))
                                     ? '0 : wslot_reg + 1'b1;
                        fill_reg  <= fill_next;
                        k_reg     <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (scan_end) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sum, minimum and maximum accumulate as ring data returns
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end else if (rd_valid_reg) begin
            sum_reg <= sum_reg + SUM_W'(rd_data);
            if (rd_data < min_reg) begin
                min_reg <= rd_data;
            end
            if (rd_data > max_reg) begin
                max_reg <= rd_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            mean_reg   <= quotient;
            spread_reg <= max_reg - min_reg;
            count_reg  <= fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mean_value = mean_reg;
    assign m_spread     = spread_reg;
    assign m_held_count = count_reg;

endmodule

`default_nettype wire
